/* hdl/svm_pkg.sv */
// ----------------------------------------------------------------------------
// svm_pkg: shared types and microcode for the sample voice mixer
// Holds the command codes, register indexes, control word layout and the
// read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package svm_pkg;

   // Default sizes
   localparam int DEF_VOICES       = 8;
   localparam int DEF_SAMPLE_WORDS = 65536;

   // Volume a voice starts with on play
   localparam logic [7:0] START_VOLUME = 8'd128;

   // Command codes of the request channel
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_PLAY   = 2'd1;
   localparam logic [1:0] CMD_VOLUME = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   // Configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_USE   = 1'd1;

   // Microprogram addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_FETCH      = 4'd0;
   localparam logic [PC_W-1:0] PC_WRITE      = 4'd1;
   localparam logic [PC_W-1:0] PC_PICK_INIT  = 4'd2;
   localparam logic [PC_W-1:0] PC_PICK_SCAN  = 4'd3;
   localparam logic [PC_W-1:0] PC_PLAY_NAMED = 4'd4;
   localparam logic [PC_W-1:0] PC_PLAY_START = 4'd5;
   localparam logic [PC_W-1:0] PC_SET_VOL    = 4'd6;
   localparam logic [PC_W-1:0] PC_MIX_INIT   = 4'd7;
   localparam logic [PC_W-1:0] PC_MIX_RUN    = 4'd8;
   localparam logic [PC_W-1:0] PC_MIX_DRAIN  = 4'd9;
   localparam logic [PC_W-1:0] PC_MIX_SAT    = 4'd10;
   localparam logic [PC_W-1:0] PC_PUBLISH    = 4'd11;

   // Datapath operation of one step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_FETCH,
      OP_WRITE,
      OP_PICK_INIT,
      OP_PICK_SCAN,
      OP_PLAY_NAMED,
      OP_PLAY_START,
      OP_SET_VOL,
      OP_MIX_INIT,
      OP_MIX_RUN,
      OP_MIX_SAT,
      OP_PUBLISH
   } op_type;

   // Jump condition of one step
   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_ACCEPT,
      COND_MANUAL,
      COND_PICK_DONE,
      COND_MIX_OVER,
      COND_OUT_FREE
   } cond_type;

   // One control word: on a met condition jump to target, else advance or hold
   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
      logic            advance;
   } uword_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic       accept;
      logic [1:0] cmd;
      logic       manual;
      logic       pick_done;
      logic       mix_over;
      logic       out_free;
   } status_type;

   function automatic uword_type make_uword(op_type op, cond_type cond,
                                            logic [PC_W-1:0] target, logic advance);
      uword_type w;
      w.op      = op;
      w.cond    = cond;
      w.target  = target;
      w.advance = advance;
      return w;
   endfunction

   // Microprogram ROM
   function automatic uword_type ucode(logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         PC_FETCH:      w = make_uword(OP_FETCH,      COND_ACCEPT,    PC_FETCH,      1'b0);
         PC_WRITE:      w = make_uword(OP_WRITE,      COND_ALWAYS,    PC_PUBLISH,    1'b0);
         PC_PICK_INIT:  w = make_uword(OP_PICK_INIT,  COND_MANUAL,    PC_PLAY_NAMED, 1'b1);
         PC_PICK_SCAN:  w = make_uword(OP_PICK_SCAN,  COND_PICK_DONE, PC_PLAY_START, 1'b0);
         PC_PLAY_NAMED: w = make_uword(OP_PLAY_NAMED, COND_ALWAYS,    PC_PLAY_START, 1'b0);
         PC_PLAY_START: w = make_uword(OP_PLAY_START, COND_ALWAYS,    PC_PUBLISH,    1'b0);
         PC_SET_VOL:    w = make_uword(OP_SET_VOL,    COND_ALWAYS,    PC_PUBLISH,    1'b0);
         PC_MIX_INIT:   w = make_uword(OP_MIX_INIT,   COND_ALWAYS,    PC_MIX_RUN,    1'b0);
         PC_MIX_RUN:    w = make_uword(OP_MIX_RUN,    COND_MIX_OVER,  PC_MIX_DRAIN,  1'b0);
         PC_MIX_DRAIN:  w = make_uword(OP_MIX_RUN,    COND_ALWAYS,    PC_MIX_SAT,    1'b0);
         PC_MIX_SAT:    w = make_uword(OP_MIX_SAT,    COND_ALWAYS,    PC_PUBLISH,    1'b0);
         PC_PUBLISH:    w = make_uword(OP_PUBLISH,    COND_OUT_FREE,  PC_FETCH,      1'b0);
         default:       w = make_uword(OP_NOP,        COND_ALWAYS,    PC_FETCH,      1'b0);
      endcase
      return w;
   endfunction

   // Entry point of each command
   function automatic logic [PC_W-1:0] dispatch(logic [1:0] cmd);
      logic [PC_W-1:0] pc;
      case (cmd)
         CMD_WRITE:  pc = PC_WRITE;
         CMD_PLAY:   pc = PC_PICK_INIT;
         CMD_VOLUME: pc = PC_SET_VOL;
         CMD_TICK:   pc = PC_MIX_INIT;
         default:    pc = PC_FETCH;
      endcase
      return pc;
   endfunction

endpackage

/* hdl/svm_seq.sv */
// ----------------------------------------------------------------------------
// svm_seq: microcode sequencer of the sample voice mixer
// Holds the step counter, reads the control word from the program ROM and
// picks the next step from the jump condition and the datapath status.
// ----------------------------------------------------------------------------
module svm_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  svm_pkg::status_type    status,
   output svm_pkg::uword_type     uword
);

   logic [svm_pkg::PC_W-1:0] pc_ff;
   logic [svm_pkg::PC_W-1:0] pc_in;
   logic [svm_pkg::PC_W-1:0] target;
   logic                     cond_met;

   // Read the control word of the current step
   assign uword = svm_pkg::ucode(pc_ff);

   // Evaluate the jump condition
   always_comb begin
      case (uword.cond)
         svm_pkg::COND_ALWAYS:    cond_met = 1'b1;
         svm_pkg::COND_ACCEPT:    cond_met = status.accept;
         svm_pkg::COND_MANUAL:    cond_met = status.manual;
         svm_pkg::COND_PICK_DONE: cond_met = status.pick_done;
         svm_pkg::COND_MIX_OVER:  cond_met = status.mix_over;
         svm_pkg::COND_OUT_FREE:  cond_met = status.out_free;
         default:                 cond_met = 1'b0;
      endcase
   end

   // Jump, advance or hold
   always_comb begin
      if (uword.cond == svm_pkg::COND_ACCEPT) begin
         target = svm_pkg::dispatch(status.cmd);
      end else begin
         target = uword.target;
      end
      if (cond_met) begin
         pc_in = target;
      end else if (uword.advance) begin
         pc_in = pc_ff + 1'b1;
      end else begin
         pc_in = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= svm_pkg::PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* hdl/sample_voice_mixer_unit.sv */
// Auto play scans the voices in turn up to the first idle one, or all of them
// when none is idle; a tick mixes each playing voice in use. A result sits in the
// output register until taken; the next transaction is accepted in the cycle after
// the load. Reset idles all voices and restores the registers; the store is not
// cleared.
// ----------------------------------------------------------------------------
// sample_voice_mixer_unit: multi-voice PCM sample mixer
// Sample store, voice table and mixing datapath driven by a microcoded
// sequencer. SAMPLE_WORDS is a power of two; store addresses wrap at it.
// ----------------------------------------------------------------------------
module sample_voice_mixer_unit #(
   parameter int VOICES       = svm_pkg::DEF_VOICES,
   parameter int SAMPLE_WORDS = svm_pkg::DEF_SAMPLE_WORDS
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_en,
   input  logic [svm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [3:0]                    csr_wdata,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [15:0]                   req_sample_addr,
   input  logic signed [15:0]            req_sample_value,
   input  logic [16:0]                   req_clip_length,
   input  logic [2:0]                    req_voice_index,
   input  logic                          req_auto_pick,
   input  logic [7:0]                    req_new_volume,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [15:0]            rsp_left_sample,
   output logic signed [15:0]            rsp_right_sample,
   output logic [2:0]                    rsp_assigned_voice,
   output logic                          rsp_no_voice_free
);

   localparam int AW    = $clog2(SAMPLE_WORDS);
   localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W = $clog2(VOICES + 1);
   localparam int N_W   = (CNT_W > 4) ? CNT_W : 4;
   localparam int SUM_W = (AW > 18) ? AW : 18;
   localparam int ACC_W = 18 + VW;

   svm_pkg::uword_type  uword;
   svm_pkg::status_type status;

   // Configuration registers
   logic [3:0] reserved_ff;
   logic [3:0] in_use_ff;

   // Latched transaction
   logic [1:0]         cmd_ff;
   logic [15:0]        addr_ff;
   logic signed [15:0] value_ff;
   logic [16:0]        length_ff;
   logic [2:0]         vidx_ff;
   logic               auto_ff;
   logic [7:0]         volume_ff;

   // Voice table
   logic [15:0]        v_start_ff  [VOICES];
   logic [16:0]        v_length_ff [VOICES];
   logic [16:0]        v_pos_ff    [VOICES];
   logic [7:0]         v_vol_ff    [VOICES];
   logic [VOICES-1:0]  v_playing_ff;

   // Sample store
   logic signed [15:0] store_mem [SAMPLE_WORDS];
   logic signed [15:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic [SUM_W-1:0]   rd_sum;

   // Scan and mix datapath
   logic [N_W-1:0]     idx_ff;
   logic [VW-1:0]      sel_ff;
   logic               sel_ok_ff;
   logic [16:0]        best_pos_ff;
   logic               act1_ff;
   logic [7:0]         vol1_ff;
   logic signed [24:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   // Result being built
   logic signed [15:0] res_mix_ff;
   logic [2:0]         res_assigned_ff;
   logic               res_nofree_ff;

   // Output register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_mix_ff;
   logic [2:0]         rsp_assigned_ff;
   logic               rsp_nofree_ff;

   logic [N_W-1:0]     n_cnt;
   logic [VW-1:0]      cur;
   logic               live;
   logic               cur_playing;
   logic               cur_active;
   logic [16:0]        pos_in;
   logic               vidx_ok;
   logic               accept;
   logic               out_free;
   logic signed [16:0] scaled;

   svm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   // Voices mixed and open for picking
   assign n_cnt = (N_W'(in_use_ff) > N_W'(VOICES)) ? N_W'(VOICES) : N_W'(in_use_ff);

   // Current voice of the scan or mix loop
   assign cur         = idx_ff[VW-1:0];
   assign live        = idx_ff < n_cnt;
   assign cur_playing = v_playing_ff[cur];
   assign cur_active  = cur_playing && (v_pos_ff[cur] < v_length_ff[cur]);
   assign pos_in      = cur_active ? v_pos_ff[cur] + 17'd1 : v_pos_ff[cur];
   assign vidx_ok     = 32'(vidx_ff) < 32'(VOICES);

   // Clip read address, wrapped at the store size
   assign rd_sum  = SUM_W'(v_start_ff[cur]) + SUM_W'(v_pos_ff[cur]);
   assign rd_addr = rd_sum[AW-1:0];

   // Handshake
   assign req_stall = (uword.op != svm_pkg::OP_FETCH);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Status to the sequencer
   always_comb begin
      status.accept    = accept;
      status.cmd       = req_cmd;
      status.manual    = !auto_ff;
      status.pick_done = !live || !cur_playing;
      status.mix_over  = !live;
      status.out_free  = out_free;
   end

   assign scaled = 17'(prod_ff >>> 8);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= 4'd0;
         in_use_ff   <= 4'd8;
      end else if (csr_write_en) begin
         case (csr_index)
            svm_pkg::CSR_RESERVED: reserved_ff <= csr_wdata;
            svm_pkg::CSR_IN_USE:   in_use_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         addr_ff   <= req_sample_addr;
         value_ff  <= req_sample_value;
         length_ff <= req_clip_length;
         vidx_ff   <= req_voice_index;
         auto_ff   <= req_auto_pick;
         volume_ff <= req_new_volume;
      end
   end

   // Sample store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (uword.op == svm_pkg::OP_WRITE) begin
         store_mem[AW'(addr_ff)] <= value_ff;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Voice playing flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v_playing_ff <= '0;
      end else begin
         case (uword.op)
            svm_pkg::OP_PLAY_START: begin
               if (sel_ok_ff) begin
                  v_playing_ff[sel_ff] <= 1'b1;
               end
            end
            svm_pkg::OP_MIX_RUN: begin
               if (live && cur_playing) begin
                  v_playing_ff[cur] <= pos_in < v_length_ff[cur];
               end
            end
            default: ;
         endcase
      end
   end

   // Voice table payload
   always_ff @(posedge clock) begin
      case (uword.op)
         svm_pkg::OP_PLAY_START: begin
            if (sel_ok_ff) begin
               v_start_ff[sel_ff]  <= addr_ff;
               v_length_ff[sel_ff] <= length_ff;
               v_pos_ff[sel_ff]    <= 17'd0;
               v_vol_ff[sel_ff]    <= svm_pkg::START_VOLUME;
            end
         end
         svm_pkg::OP_SET_VOL: begin
            if (vidx_ok) begin
               v_vol_ff[VW'(vidx_ff)] <= volume_ff;
            end
         end
         svm_pkg::OP_MIX_RUN: begin
            if (live && cur_playing) begin
               v_pos_ff[cur] <= pos_in;
            end
         end
         default: ;
      endcase
   end

   // Voice pick (first idle, else furthest into its clip), named pick, mix loop index
   always_ff @(posedge clock) begin
      case (uword.op)
         svm_pkg::OP_PICK_INIT: begin
            idx_ff      <= N_W'(reserved_ff);
            sel_ok_ff   <= 1'b0;
            best_pos_ff <= 17'd0;
         end
         svm_pkg::OP_PICK_SCAN: begin
            if (live) begin
               if (!cur_playing) begin
                  sel_ff    <= cur;
                  sel_ok_ff <= 1'b1;
               end else if (!sel_ok_ff || (v_pos_ff[cur] > best_pos_ff)) begin
                  sel_ff      <= cur;
                  sel_ok_ff   <= 1'b1;
                  best_pos_ff <= v_pos_ff[cur];
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         svm_pkg::OP_PLAY_NAMED: begin
            sel_ff    <= VW'(vidx_ff);
            sel_ok_ff <= vidx_ok;
         end
         svm_pkg::OP_MIX_INIT: begin
            idx_ff <= '0;
         end
         svm_pkg::OP_MIX_RUN: begin
            if (live) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Mix pipeline: read, multiply, accumulate, one voice per cycle
   always_ff @(posedge clock) begin
      case (uword.op)
         svm_pkg::OP_MIX_INIT: begin
            act1_ff <= 1'b0;
            prod_ff <= '0;
            acc_ff  <= '0;
         end
         svm_pkg::OP_MIX_RUN: begin
            act1_ff <= live && cur_active;
            vol1_ff <= v_vol_ff[cur];
            prod_ff <= act1_ff ? rd_data_ff * $signed({1'b0, vol1_ff}) : 25'sd0;
            acc_ff  <= acc_ff + ACC_W'(scaled);
         end
         default: ;
      endcase
   end

   // Build the result fields
   always_ff @(posedge clock) begin
      case (uword.op)
         svm_pkg::OP_FETCH: begin
            res_mix_ff      <= 16'sd0;
            res_assigned_ff <= 3'd0;
            res_nofree_ff   <= 1'b0;
         end
         svm_pkg::OP_PLAY_START: begin
            if (sel_ok_ff) begin
               res_assigned_ff <= 3'(sel_ff);
            end else begin
               res_nofree_ff <= auto_ff;
            end
         end
         svm_pkg::OP_MIX_SAT: begin
            if (acc_ff > ACC_W'(32767)) begin
               res_mix_ff <= 16'sh7fff;
            end else if (acc_ff < -ACC_W'(32768)) begin
               res_mix_ff <= -16'sh8000;
            end else begin
               res_mix_ff <= 16'(acc_ff);
            end
         end
         default: ;
      endcase
   end

   // Output register: load on publish, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((uword.op == svm_pkg::OP_PUBLISH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((uword.op == svm_pkg::OP_PUBLISH) && out_free) begin
         rsp_mix_ff      <= (cmd_ff == svm_pkg::CMD_TICK) ? res_mix_ff : 16'sd0;
         rsp_assigned_ff <= res_assigned_ff;
         rsp_nofree_ff   <= res_nofree_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_sample    = rsp_mix_ff;
   assign rsp_right_sample   = rsp_mix_ff;
   assign rsp_assigned_voice = rsp_assigned_ff;
   assign rsp_no_voice_free  = rsp_nofree_ff;

endmodule

/* tb/tb_sample_voice_mixer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_voice_mixer_unit: self-checking bench for the sample voice mixer
// Drives sample writes, clip plays, volume changes and frame ticks through the
// request channel. A behavioral copy of the voice table and sample store
// predicts each response. Both channels idle at random. Register settings
// change between phases, with the block drained.
// ----------------------------------------------------------------------------
module tb_sample_voice_mixer_unit;

   localparam int VOICES          = svm_pkg::DEF_VOICES;
   localparam int QUIET_LIMIT     = 4000;
   localparam int DRAIN_WAIT      = 20;
   localparam int ITEMS_PER_PHASE = 150;

   // One request transaction
   typedef struct {
      logic [1:0]         cmd;
      logic [15:0]        addr;
      logic signed [15:0] value;
      logic [16:0]        length;
      logic [2:0]         voice;
      logic               auto_pick;
      logic [7:0]         volume;
   } mixer_cmd_type;

   // One response transaction
   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [2:0]         voice;
      logic               no_free;
   } frame_result_type;

   typedef struct {
      logic [15:0] start;
      logic [16:0] length;
      logic [16:0] position;
      logic [7:0]  volume;
      bit          playing;
   } voice_state_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic [svm_pkg::CSR_IDX_W-1:0]  csr_index = svm_pkg::CSR_RESERVED;
   logic [3:0]                     csr_wdata = 4'd0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_cmd = svm_pkg::CMD_WRITE;
   logic [15:0]                    req_sample_addr = 16'd0;
   logic signed [15:0]             req_sample_value = 16'sd0;
   logic [16:0]                    req_clip_length = 17'd0;
   logic [2:0]                     req_voice_index = 3'd0;
   logic                           req_auto_pick = 1'b0;
   logic [7:0]                     req_new_volume = 8'd0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [15:0]             rsp_left_sample;
   logic signed [15:0]             rsp_right_sample;
   logic [2:0]                     rsp_assigned_voice;
   logic                           rsp_no_voice_free;

   // Predicted block state
   logic signed [15:0] sample_words [0:65535];
   bit                 word_written [0:65535];
   voice_state_type    voices [VOICES];
   logic [3:0]         cfg_reserved = 4'd0;
   logic [3:0]         cfg_in_use = 4'd8;

   frame_result_type expected_frames [$];
   int               fail_count = 0;
   int               quiet_cycles = 0;
   int               items_sent = 0;
   bit               idle_enable = 1'b1;

   sample_voice_mixer_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_sample_addr    (req_sample_addr),
      .req_sample_value   (req_sample_value),
      .req_clip_length    (req_clip_length),
      .req_voice_index    (req_voice_index),
      .req_auto_pick      (req_auto_pick),
      .req_new_volume     (req_new_volume),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_sample    (rsp_left_sample),
      .rsp_right_sample   (rsp_right_sample),
      .rsp_assigned_voice (rsp_assigned_voice),
      .rsp_no_voice_free  (rsp_no_voice_free)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // An in-use setting above the voice count acts as the voice count
   function automatic int mixed_voices();
      return (cfg_in_use > VOICES) ? VOICES : int'(cfg_in_use);
   endfunction

   // First idle allocatable voice, else the one furthest into its clip
   function automatic int pick_voice();
      int     n;
      int     best;
      longint best_pos;
      n        = mixed_voices();
      best     = -1;
      best_pos = -1;
      for (int i = int'(cfg_reserved); i < n; i++) begin
         if (!voices[i].playing) return i;
         if (longint'(voices[i].position) > best_pos) begin
            best_pos = longint'(voices[i].position);
            best     = i;
         end
      end
      return best;
   endfunction

   // Apply one transaction to the predicted state and return its response
   function automatic frame_result_type predict_frame(input mixer_cmd_type c);
      frame_result_type r;
      int               picked;
      int               acc;
      int               term;
      logic [15:0]      a;
      r.left    = '0;
      r.right   = '0;
      r.voice   = '0;
      r.no_free = 1'b0;
      picked    = -1;
      acc       = 0;
      case (c.cmd)
         svm_pkg::CMD_WRITE: begin
            sample_words[c.addr] = c.value;
            word_written[c.addr] = 1'b1;
         end
         svm_pkg::CMD_PLAY: begin
            if (c.auto_pick) begin
               picked = pick_voice();
               if (picked < 0) r.no_free = 1'b1;
            end else begin
               picked = int'(c.voice);
            end
            if (picked >= 0) begin
               voices[picked].start    = c.addr;
               voices[picked].length   = c.length;
               voices[picked].position = '0;
               voices[picked].volume   = svm_pkg::START_VOLUME;
               voices[picked].playing  = 1'b1;
               r.voice = 3'(picked);
            end
         end
         svm_pkg::CMD_VOLUME: begin
            voices[c.voice].volume = c.volume;
         end
         default: begin
            // mix each playing voice in use and advance it, stop at clip end
            for (int i = 0; i < mixed_voices(); i++) begin
               if (voices[i].playing) begin
                  if (voices[i].position < voices[i].length) begin
                     a    = voices[i].start + voices[i].position[15:0];
                     term = int'(sample_words[a]) * int'(voices[i].volume);
                     acc  = acc + (term >>> 8);
                     voices[i].position = voices[i].position + 17'd1;
                  end
                  if (voices[i].position >= voices[i].length) voices[i].playing = 1'b0;
               end
            end
            if (acc > 32767) acc = 32767;
            else if (acc < -32768) acc = -32768;
            r.left  = 16'(acc);
            r.right = 16'(acc);
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Every field random; callers override the ones the command uses
   function automatic mixer_cmd_type random_fields();
      mixer_cmd_type c;
      c.cmd       = 2'($urandom);
      c.addr      = 16'($urandom);
      c.value     = 16'($urandom);
      c.length    = 17'($urandom);
      c.voice     = 3'($urandom);
      c.auto_pick = 1'($urandom);
      c.volume    = 8'($urandom);
      return c;
   endfunction

   // Mostly a low window and the top of the store, so clips reuse written words
   function automatic logic [15:0] random_window_addr();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: return 16'($urandom_range(0, 319));
         7, 8:                return 16'hFF00 + 16'($urandom_range(0, 255));
         default:             return 16'($urandom);
      endcase
   endfunction

   function automatic mixer_cmd_type random_command();
      mixer_cmd_type c;
      int            sel;
      c   = random_fields();
      sel = $urandom_range(99);
      if (sel < 45) begin
         c.cmd  = svm_pkg::CMD_WRITE;
         c.addr = random_window_addr();
         case ($urandom_range(9))
            0:       c.value = 16'sh7FFF;
            1:       c.value = 16'sh8000;
            2:       c.value = 16'sh0000;
            default: c.value = 16'($urandom);
         endcase
      end else if (sel < 80) begin
         c.cmd  = svm_pkg::CMD_PLAY;
         c.addr = random_window_addr();
         case ($urandom_range(19))
            0:       c.length = 17'd0;
            1:       c.length = 17'd65536;
            2:       c.length = 17'h1FFFF;
            3:       c.length = 17'($urandom);
            default: c.length = 17'($urandom_range(1, 24));
         endcase
      end else begin
         c.cmd = svm_pkg::CMD_VOLUME;
         if ($urandom_range(3) == 0) c.volume = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return c;
   endfunction

   // Present one transaction, wait for its acceptance, record its response
   task automatic send_item(input mixer_cmd_type c);
      while (idle_enable && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_cmd          <= c.cmd;
      req_sample_addr  <= c.addr;
      req_sample_value <= c.value;
      req_clip_length  <= c.length;
      req_voice_index  <= c.voice;
      req_auto_pick    <= c.auto_pick;
      req_new_volume   <= c.volume;
      req_valid        <= 1'b1;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      expected_frames.push_back(predict_frame(c));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_write(input logic [15:0] addr, input logic signed [15:0] value);
      mixer_cmd_type c;
      c       = random_fields();
      c.cmd   = svm_pkg::CMD_WRITE;
      c.addr  = addr;
      c.value = value;
      send_item(c);
   endtask

   task automatic send_play(input logic [15:0] addr, input logic [16:0] length,
                            input logic [2:0] voice, input logic auto_pick);
      mixer_cmd_type c;
      c           = random_fields();
      c.cmd       = svm_pkg::CMD_PLAY;
      c.addr      = addr;
      c.length    = length;
      c.voice     = voice;
      c.auto_pick = auto_pick;
      send_item(c);
   endtask

   task automatic send_volume(input logic [2:0] voice, input logic [7:0] volume);
      mixer_cmd_type c;
      c        = random_fields();
      c.cmd    = svm_pkg::CMD_VOLUME;
      c.voice  = voice;
      c.volume = volume;
      send_item(c);
   endtask

   // Write every word the next frame will read that holds no data yet, then tick
   task automatic send_tick();
      mixer_cmd_type c;
      logic [15:0]   a;
      for (int i = 0; i < mixed_voices(); i++) begin
         if (voices[i].playing && voices[i].position < voices[i].length) begin
            a = voices[i].start + voices[i].position[15:0];
            if (!word_written[a]) send_write(a, 16'($urandom));
         end
      end
      c     = random_fields();
      c.cmd = svm_pkg::CMD_TICK;
      send_item(c);
   endtask

   // Drop valid and hold until every pending response has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
   endtask

   // Write both registers back to back while the block is idle
   task automatic set_config(input logic [3:0] reserved, input logic [3:0] in_use);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index    <= svm_pkg::CSR_RESERVED;
      csr_wdata    <= reserved;
      @(negedge clock);
      csr_index    <= svm_pkg::CSR_IN_USE;
      csr_wdata    <= in_use;
      @(negedge clock);
      csr_write_en <= 1'b0;
      cfg_reserved = reserved;
      cfg_in_use   = in_use;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Clip reads wrap from the top of the store to address zero
   task automatic test_store_wrap();
      send_write(16'hFFFF, 16'sh7FFF);
      send_write(16'h0000, 16'sh8000);
      send_play(16'hFFFF, 17'd2, 3'd3, 1'b0);
      send_tick();
      send_tick();
   endtask

   // Fill all voices by automatic pick, steal the furthest one, saturate both ways
   task automatic test_auto_pick_saturation();
      send_write(16'h0040, 16'sh7FFF);
      send_write(16'h0041, 16'sh8000);
      repeat (VOICES) send_play(16'h0040, 17'd2, 3'd0, 1'b1);
      send_tick();
      send_play(16'h0040, 17'd2, 3'd0, 1'b1);
      send_tick();
   endtask

   // Full volume, flooring of negative products, zero-length clip
   task automatic test_volume_rounding();
      send_write(16'h0042, -16'sd1);
      send_play(16'h0042, 17'd1, 3'd5, 1'b0);
      send_volume(3'd5, 8'hFF);
      send_play(16'h0000, 17'd0, 3'd6, 1'b0);
      send_tick();
   endtask

   // Register extremes: nothing to pick, no voice mixed, values above range
   task automatic test_register_extremes();
      set_config(4'd8, 4'd8);
      send_play(16'h0040, 17'd1, 3'd0, 1'b1);
      set_config(4'd0, 4'd0);
      send_play(16'h0040, 17'd1, 3'd7, 1'b0);
      send_tick();
      send_play(16'h0040, 17'd1, 3'd0, 1'b1);
      set_config(4'd15, 4'd15);
      send_tick();
      send_play(16'h0040, 17'd1, 3'd0, 1'b1);
      set_config(4'd7, 4'd8);
      send_play(16'h0041, 17'd1, 3'd0, 1'b1);
   endtask

   // Random traffic in phases, one phase without any idling
   task automatic test_random_traffic();
      int phase_reserved [8] = '{0, 3, 0, 7, 2, 0, 12, 5};
      int phase_in_use   [8] = '{8, 8, 4, 8, 15, 1, 3, 6};
      int phase_end;
      for (int p = 0; p < 8; p++) begin
         set_config(4'(phase_reserved[p]), 4'(phase_in_use[p]));
         idle_enable = (p != 3);
         phase_end   = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            if ($urandom_range(99) < 35) send_tick();
            else send_item(random_command());
         end
      end
      idle_enable = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(99) < 12);
   end

   task automatic note_failure(input string what, input int want, input int got);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s mismatch: expected %0d, got %0d", $realtime,
                                     what, want, got);
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_response
      frame_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_frames.size() == 0) begin
            note_failure("unexpected response", 0, 1);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_left_sample !== want.left)
               note_failure("left_sample", want.left, rsp_left_sample);
            if (rsp_right_sample !== want.right)
               note_failure("right_sample", want.right, rsp_right_sample);
            if (rsp_assigned_voice !== want.voice)
               note_failure("assigned_voice", want.voice, rsp_assigned_voice);
            if (rsp_no_voice_free !== want.no_free)
               note_failure("no_voice_free", want.no_free, rsp_no_voice_free);
         end
      end
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      for (int i = 0; i < VOICES; i++) begin
         voices[i].start    = '0;
         voices[i].length   = '0;
         voices[i].position = '0;
         voices[i].volume   = '0;
         voices[i].playing  = 1'b0;
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_store_wrap();
      test_auto_pick_saturation();
      test_volume_rounding();
      test_register_extremes();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      if (fail_count == 0 && expected_frames.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
